### rtl/sem_pkg.sv
package sem_pkg;

  // configuration register file
  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd480;

  // frame size limits
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  // input item commands
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // gradient queue
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  localparam int GW = 12;  // signed Sobel sum, |g| <= 1020

  typedef struct packed {
    logic       cmd;
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
  } sem_in_t;

  typedef struct packed {
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
    logic       frame_done;
  } sem_out_t;

  // one queued result: gradients per channel (blue, green, red) and end-of-frame flag
  typedef struct packed {
    logic [2:0][GW-1:0] gx;
    logic [2:0][GW-1:0] gy;
    logic               done;
  } sem_grad_t;

  typedef struct packed {
    logic      valid;
    sem_grad_t entry;
  } sem_push_t;

endpackage

### rtl/sem_stream_if.sv
interface sem_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/sobel_edge_magnitude_rgb_unit.sv
// 3x3 Sobel edge magnitude on an RGB raster stream.
// pix_in (valid/ready): one item per transfer, cmd selects pixel or flush tick.
// pix_out (valid/ready): per-channel magnitude min(255, round(sqrt(gx^2+gy^2))),
//   frame_done set on the result of the frame's last pixel.
// cfg port: write-only, index 0 frame width, index 1 frame height; a write
//   restarts the frame. Write only while nothing is in flight.
// Result for raster pixel k is produced by the item at position k+width+1;
//   width+1 flush ticks after the last pixel drain the frame.
// Front end takes a new input once the last one is through line buffer read,
//   write-back and Sobel sums, then pushes gradients into a 4-entry queue.
// Back end: square, one-bit-per-cycle square root (nine bits), round; it
//   takes the next queue entry only after rounding, which sets sustained throughput.
// Reset: registers go to 640x480, position counters and window clear;
//   line buffers are not cleared (unused entries are masked at frame edges).
// A stalled receiver holds the output register; the back end parks in its
//   final step and the queue fills, after which pix_in.ready drops.
module sobel_edge_magnitude_rgb_unit
  import sem_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  sem_stream_if.sink           pix_in,
  sem_stream_if.source         pix_out
);

  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int WCW = (WW > CFG_W) ? WW : CFG_W;
  localparam int HCW = (HW > CFG_W) ? HW : CFG_W;

  logic [CFG_W-1:0] width_q, height_q;
  logic [WW-1:0]    width_eff;
  logic [HW-1:0]    height_eff;
  logic [WCW-1:0]   wx;
  logic [HCW-1:0]   hx;

  sem_push_t q_push;
  sem_grad_t q_head;
  logic      q_empty, q_full, q_pop;
  sem_in_t   in_data;
  sem_out_t  out_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= FRAME_WIDTH_RST;
      height_q <= FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_WIDTH:  width_q  <= cfg_data_i;
        REG_FRAME_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // zero acts as 1, anything above the limit as the limit
  always_comb begin
    wx = WCW'(width_q);
    hx = HCW'(height_q);
    if (wx == '0)                  width_eff = WW'(1);
    else if (wx > WCW'(MAX_WIDTH)) width_eff = WW'(MAX_WIDTH);
    else                           width_eff = WW'(wx);
    if (hx == '0)                   height_eff = HW'(1);
    else if (hx > HCW'(MAX_HEIGHT)) height_eff = HW'(MAX_HEIGHT);
    else                            height_eff = HW'(hx);
  end

  assign in_data = pix_in.data;

  sem_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .width_i    (width_eff),
    .height_i   (height_eff),
    .restart_i  (cfg_we_i),
    .in_valid_i (pix_in.valid),
    .in_data_i  (in_data),
    .in_ready_o (pix_in.ready),
    .q_full_i   (q_full),
    .push_o     (q_push)
  );

  sem_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  sem_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (q_head),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .out_valid_o (pix_out.valid),
    .out_ready_i (pix_out.ready),
    .out_data_o  (out_data)
  );

  assign pix_out.data = out_data;

`ifndef SYNTH
  // front must never push into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push.valid |-> !q_full)
    else $error("gradient queue overflow");

  // back end pops only real entries
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("gradient queue underflow");
`endif

endmodule

### rtl/sem_front.sv
module sem_front
  import sem_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int AW = $clog2(MAX_WIDTH),
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [WW-1:0] width_i,
  input  logic [HW-1:0] height_i,
  input  logic          restart_i,
  input  logic          in_valid_i,
  input  sem_in_t       in_data_i,
  output logic          in_ready_o,
  input  logic          q_full_i,
  output sem_push_t     push_o
);

  localparam int RW = $clog2(MAX_HEIGHT + 2);
  localparam int RX = RW + 2;

  logic [AW-1:0] col_q;
  logic [RW-1:0] row_q;

  logic          s1_q, s2_q;
  logic [AW-1:0] s1_addr_q;
  logic [23:0]   s1_pix_q;
  logic [2:0]    s1_rm_q, s1_cm_q, s2_rm_q, s2_cm_q;
  logic          s1_emit_q, s1_done_q, s2_emit_q, s2_done_q;

  logic [47:0] lb_mem [MAX_WIDTH];  // {upper, middle}
  logic [47:0] lb_rd_q;
  logic [23:0] win_q [9];

  logic          accept, past_end, live, emit, done, wrap;
  logic [RX-1:0] tx, hx, sh, k;
  logic [2:0]    rm, cm;
  logic [23:0]   pix;
  logic signed [GW-1:0] p [9];
  sem_grad_t     grad;

  assign in_ready_o = !s1_q && !s2_q && !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign past_end   = row_q >= RW'(height_i);
  // a flush while pixels are still due is dropped without effect
  assign live       = accept && (past_end || in_data_i.cmd == CMD_PIXEL);
  assign pix        = past_end ? 24'd0
                    : {in_data_i.red_in, in_data_i.green_in, in_data_i.blue_in};

  always_comb begin
    tx = RX'(row_q);
    hx = RX'(height_i);
    sh = (col_q == '0) ? RX'(3) : RX'(2);
    for (int r = 0; r < 3; r++) begin
      k     = sh - RX'(r);
      rm[r] = (tx >= k) && (tx < hx + k);
    end
    if (col_q == '0) cm = {1'b0, 1'b1, width_i >= WW'(2)};
    else             cm = {1'b1, 1'b1, col_q >= AW'(2)};
    emit = (row_q >= RW'(2)) || (row_q == RW'(1) && col_q != '0);
    done = (col_q == '0) && (tx == hx + RX'(1));
    wrap = (WW'(col_q) + WW'(1)) >= width_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (restart_i || (live && done)) begin
      col_q <= '0;
      row_q <= '0;
    end else if (live) begin
      if (wrap) begin
        col_q <= '0;
        row_q <= row_q + RW'(1);
      end else begin
        col_q <= col_q + AW'(1);
      end
    end
  end

  // line buffers: read when a live item is taken, written back in the cycle after
  always_ff @(posedge clk_i) begin
    if (live) lb_rd_q <= lb_mem[col_q];
    if (s1_q) lb_mem[s1_addr_q] <= {lb_rd_q[23:0], s1_pix_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0;
      s2_q <= 1'b0;
    end else begin
      s1_q <= live;
      s2_q <= s1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (live) begin
      s1_addr_q <= col_q;
      s1_pix_q  <= pix;
      s1_rm_q   <= rm;
      s1_cm_q   <= cm;
      s1_emit_q <= emit;
      s1_done_q <= done;
    end
    if (s1_q) begin
      s2_rm_q   <= s1_rm_q;
      s2_cm_q   <= s1_cm_q;
      s2_emit_q <= s1_emit_q;
      s2_done_q <= s1_done_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) win_q[i] <= '0;
    end else if (s1_q) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r*3]   <= win_q[r*3+1];
        win_q[r*3+1] <= win_q[r*3+2];
      end
      win_q[2] <= lb_rd_q[47:24];
      win_q[5] <= lb_rd_q[23:0];
      win_q[8] <= s1_pix_q;
    end
  end

  // Sobel sums with out-of-frame taps forced to zero
  always_comb begin
    grad      = '0;
    grad.done = s2_done_q;
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          p[r*3+c] = (s2_rm_q[r] && s2_cm_q[c]) ? GW'(win_q[r*3+c][8*ch +: 8]) : '0;
        end
      end
      grad.gx[ch] = (p[2] + (p[5] <<< 1) + p[8]) - (p[0] + (p[3] <<< 1) + p[6]);
      grad.gy[ch] = (p[6] + (p[7] <<< 1) + p[8]) - (p[0] + (p[1] <<< 1) + p[2]);
    end
  end

  assign push_o.valid = s2_q && s2_emit_q;
  assign push_o.entry = grad;

endmodule

### rtl/sem_queue.sv
module sem_queue
  import sem_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sem_push_t push_i,
  input  logic      pop_i,
  output sem_grad_t head_o,
  output logic      empty_o,
  output logic      full_o
);

  sem_grad_t      mem_q [QDEPTH];
  logic [QAW-1:0] wr_q, rd_q;
  logic [QAW:0]   cnt_q;

  assign empty_o = cnt_q == '0;
  assign full_o  = cnt_q == (QAW+1)'(QDEPTH);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i.valid) mem_q[wr_q] <= push_i.entry;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i.valid) wr_q <= wr_q + QAW'(1);
      if (pop_i)        rd_q <= rd_q + QAW'(1);
      if (push_i.valid && !pop_i)      cnt_q <= cnt_q + (QAW+1)'(1);
      else if (pop_i && !push_i.valid) cnt_q <= cnt_q - (QAW+1)'(1);
    end
  end

endmodule

### rtl/sem_back.sv
module sem_back
  import sem_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sem_grad_t head_i,
  input  logic      empty_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output sem_out_t  out_data_o
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_SQR  = 2'd1;
  localparam logic [1:0] B_ROOT = 2'd2;
  localparam logic [1:0] B_FIN  = 2'd3;

  logic [1:0]  st_q, st_d;
  sem_grad_t   g_q;
  logic [20:0] s_q [3];
  logic [8:0]  n_q [3];
  logic [3:0]  cnt_q;
  logic        out_valid_q;
  sem_out_t    out_q;

  logic signed [23:0] sqx [3];
  logic signed [23:0] sqy [3];
  logic [8:0]  t [3];
  logic [17:0] tsq [3];
  logic [18:0] nn [3];
  logic [9:0]  rnd [3];
  logic [7:0]  res [3];
  logic        fin_go;

  assign pop_o       = st_q == B_IDLE && !empty_i;
  assign fin_go      = st_q == B_FIN && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sqx[ch] = $signed(g_q.gx[ch]) * $signed(g_q.gx[ch]);
      sqy[ch] = $signed(g_q.gy[ch]) * $signed(g_q.gy[ch]);
      t[ch]   = n_q[ch] | (9'd1 << cnt_q);
      tsq[ch] = t[ch] * t[ch];
      nn[ch]  = 19'(n_q[ch] * n_q[ch]) + 19'(n_q[ch]);
      // round to nearest: step up when s lies above n*n + n
      rnd[ch] = 10'(n_q[ch]) + ((s_q[ch] > 21'(nn[ch])) ? 10'd1 : 10'd0);
      res[ch] = (s_q[ch] > 21'd65280 || rnd[ch] > 10'd255) ? 8'd255 : rnd[ch][7:0];
    end
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      B_IDLE:  if (pop_o) st_d = B_SQR;
      B_SQR:   st_d = B_ROOT;
      B_ROOT:  if (cnt_q == 4'd0) st_d = B_FIN;
      B_FIN:   if (fin_go) st_d = B_IDLE;
      default: st_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= B_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == B_SQR)       cnt_q <= 4'd8;
      else if (st_q == B_ROOT) cnt_q <= cnt_q - 4'd1;
      if (fin_go)           out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // one root bit per cycle, all three channels in lockstep
  always_ff @(posedge clk_i) begin
    if (pop_o) g_q <= head_i;
    for (int ch = 0; ch < 3; ch++) begin
      if (st_q == B_SQR) begin
        s_q[ch] <= 21'(sqx[ch]) + 21'(sqy[ch]);
        n_q[ch] <= '0;
      end else if (st_q == B_ROOT) begin
        if ({3'b000, tsq[ch]} <= s_q[ch]) n_q[ch] <= t[ch];
      end
    end
    if (fin_go) begin
      out_q.blue_out   <= res[0];
      out_q.green_out  <= res[1];
      out_q.red_out    <= res[2];
      out_q.frame_done <= g_q.done;
    end
  end

endmodule

### test/sobel_edge_magnitude_rgb_unit_tb.sv
`timescale 1ns / 100ps

module sobel_edge_magnitude_rgb_unit_tb;
  import sem_pkg::*;

  localparam int CLK_PERIOD  = 4;
  localparam int SETTLE_CYC  = 24;      // settle time after the last owed result
  localparam int CYCLE_LIMIT = 400000;  // generous: allows for back-end work on every result plus stalls
  localparam int INPUT_ITEMS = 450;

  logic clk_i;
  logic rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  sem_stream_if #(.payload_t(sem_in_t))  pix_in_bus ();
  sem_stream_if #(.payload_t(sem_out_t)) pix_out_bus ();

  sobel_edge_magnitude_rgb_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pix_in     (pix_in_bus),
    .pix_out    (pix_out_bus)
  );

  // ---------------------------------------------------------------------------
  // Edge predictor state: its own copy of line buffers, window and counters
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  logic [23:0]      row_above [DEF_MAX_WIDTH];
  logic [23:0]      row_mid   [DEF_MAX_WIDTH];
  logic [23:0]      window    [9];
  int               col_pos;
  int               row_pos;
  int               result_idx;

  sem_out_t expected_mags[$];  // magnitudes still owed by the block
  int       error_count;
  int       items_sent;
  int       cycle_count;

  // sender burst bookkeeping
  int burst_left;

  function automatic int clamp_dim(logic [CFG_W-1:0] v, int maxv);
    if (v == 0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  // min(255, round(sqrt(s)))
  function automatic logic [7:0] edge_mag(int s);
    int n;
    if (s > 255 * 255 + 255) return 8'd255;
    n = 0;
    while ((n + 1) * (n + 1) <= s) n++;
    if (s > n * n + n) n++;
    return (n > 255) ? 8'd255 : n[7:0];
  endfunction

  function automatic void restart_frame();
    col_pos    = 0;
    row_pos    = 0;
    result_idx = 0;
  endfunction

  // Advance the predictor by one accepted transfer; queue the result it causes.
  function automatic void predict_edges(sem_in_t it);
    int          w, h, x, cy, cx, gx, gy, v, prow, pcol;
    logic [23:0] pix, top, mid;
    logic [7:0]  mag [3];
    sem_out_t    res;
    w = clamp_dim(width_reg, DEF_MAX_WIDTH);
    h = clamp_dim(height_reg, DEF_MAX_HEIGHT);
    // flush while the frame still wants pixels: ignored
    if (row_pos < h && it.cmd == CMD_FLUSH) return;
    pix = (row_pos < h) ? {it.red_in, it.green_in, it.blue_in} : 24'd0;
    x = col_pos % DEF_MAX_WIDTH;
    top = row_above[x];
    mid = row_mid[x];
    row_above[x] = mid;
    row_mid[x]   = pix;
    for (int r = 0; r < 3; r++) begin
      window[r*3]   = window[r*3+1];
      window[r*3+1] = window[r*3+2];
    end
    window[2] = top;
    window[5] = mid;
    window[8] = pix;

    if (row_pos * w + col_pos >= w + 1) begin
      if (col_pos >= 1) begin
        cy = row_pos - 1;
        cx = col_pos - 1;
      end else begin
        cy = row_pos - 2;
        cx = w - 1;
      end
      for (int ch = 0; ch < 3; ch++) begin
        gx = 0;
        gy = 0;
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 3; c++) begin
            prow = cy - 1 + r;
            pcol = cx - 1 + c;
            // zero padding outside the frame
            if (prow >= 0 && prow < h && pcol >= 0 && pcol < w) begin
              v = int'(window[r*3+c][8*ch +: 8]);
              gx += v * (c - 1) * ((r == 1) ? 2 : 1);
              gy += v * (r - 1) * ((c == 1) ? 2 : 1);
            end
          end
        end
        mag[ch] = edge_mag(gx * gx + gy * gy);
      end
      res.blue_out   = mag[0];
      res.green_out  = mag[1];
      res.red_out    = mag[2];
      res.frame_done = (result_idx == w * h - 1);
      expected_mags.push_back(res);
      result_idx++;
      if (res.frame_done) begin
        restart_frame();
        return;
      end
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, cycle limit
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_mags.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready pattern switches between free-flowing, random, mostly-ready
  // and mostly-stalled.
  // ---------------------------------------------------------------------------
  int ready_mode;

  always @(posedge clk_i) begin
    if (cycle_count % 256 == 0) ready_mode <= $urandom_range(0, 3);
    case (ready_mode)
      0:       pix_out_bus.ready <= 1'b1;
      1:       pix_out_bus.ready <= 1'($urandom_range(0, 1));
      2:       pix_out_bus.ready <= ($urandom_range(0, 7) != 0);
      default: pix_out_bus.ready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result checker: every output transfer against the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    sem_out_t got, want;
    if (rst_ni && pix_out_bus.valid && pix_out_bus.ready) begin
      got = pix_out_bus.data;
      if (expected_mags.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = expected_mags.pop_front();
        if (got.blue_out != want.blue_out)
          report_mismatch("blue_out", got.blue_out, want.blue_out);
        if (got.green_out != want.green_out)
          report_mismatch("green_out", got.green_out, want.green_out);
        if (got.red_out != want.red_out)
          report_mismatch("red_out", got.red_out, want.red_out);
        if (got.frame_done != want.frame_done)
          report_mismatch("frame_done", got.frame_done, want.frame_done);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  task automatic send_item(input sem_in_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        pix_in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    pix_in_bus.valid <= 1'b1;
    pix_in_bus.data  <= it;
    do @(posedge clk_i); while (!pix_in_bus.ready);
    predict_edges(it);
    items_sent++;
  endtask

  // Drop valid and wait until every owed result arrived, then let the
  // front end settle.
  task automatic drain_results();
    pix_in_bus.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (expected_mags.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // cfg_we is lowered after each write, which keeps back-to-back writes apart.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == REG_FRAME_WIDTH) width_reg = val;
    else height_reg = val;
    restart_frame();
    @(posedge clk_i);
  endtask

  function automatic sem_in_t make_pixel(input int style);
    sem_in_t it;
    it.cmd = CMD_PIXEL;
    case (style)
      0: {it.red_in, it.green_in, it.blue_in} = 24'($urandom());
      1: begin  // saturating extremes
        it.blue_in  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        it.green_in = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        it.red_in   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      default: begin  // low contrast, keeps interior magnitudes below saturation
        it.blue_in  = 8'($urandom_range(100, 115));
        it.green_in = 8'($urandom_range(100, 103));
        it.red_in   = 8'($urandom_range(0, 7));
      end
    endcase
    return it;
  endfunction

  // One frame: w*h pixels then w+1 drain ticks. With noise on, stray flushes
  // land mid-frame (ignored) and some drain ticks carry a pixel (discarded).
  // pixels_kept < w*h cuts the frame short; the next register write restarts it.
  task automatic run_frame(input logic [CFG_W-1:0] w_val, input logic [CFG_W-1:0] h_val,
                           input int style, input bit noise, input int pixels_kept);
    int      w, h, n, pause_at;
    sem_in_t it;
    write_reg(REG_FRAME_WIDTH, w_val);
    write_reg(REG_FRAME_HEIGHT, h_val);
    w = clamp_dim(w_val, DEF_MAX_WIDTH);
    h = clamp_dim(h_val, DEF_MAX_HEIGHT);
    n = (pixels_kept < w * h) ? pixels_kept : w * h;
    pause_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n) : -1;
    for (int i = 0; i < n; i++) begin
      // sender holds off until the block has caught up completely
      if (i == pause_at) drain_results();
      if (noise && $urandom_range(0, 5) == 0) begin
        it = make_pixel(0);
        it.cmd = CMD_FLUSH;
        send_item(it);
      end
      send_item(make_pixel(style));
    end
    if (n == w * h) begin
      for (int i = 0; i <= w; i++) begin
        it = make_pixel(0);
        it.cmd = (noise && $urandom_range(0, 3) == 0) ? CMD_PIXEL : CMD_FLUSH;
        send_item(it);
      end
    end
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // 3x3 checkerboard of full-scale values, a stray flush inside the frame and
  // pixel data during the drain, then a single-pixel frame.
  task automatic test_directed_small();
    sem_in_t it;
    write_reg(REG_FRAME_WIDTH, 11'd3);
    write_reg(REG_FRAME_HEIGHT, 11'd3);
    for (int i = 0; i < 9; i++) begin
      it.cmd = CMD_PIXEL;
      it.blue_in  = (i % 2) ? 8'hFF : 8'h00;
      it.green_in = (i % 2) ? 8'h00 : 8'hFF;
      it.red_in   = (i == 4) ? 8'hFF : 8'h00;
      send_item(it);
      if (i == 4) begin
        it.cmd = CMD_FLUSH;
        send_item(it);  // ignored
      end
    end
    for (int i = 0; i < 4; i++) begin
      it.cmd = (i == 1) ? CMD_PIXEL : CMD_FLUSH;
      {it.red_in, it.green_in, it.blue_in} = 24'hFFFFFF;  // data discarded in drain
      send_item(it);
    end
    drain_results();
    run_frame(11'd1, 11'd1, 1, 1'b0, 1);  // single pixel frame
  endtask

  // Register extremes: zero clamps to one, 2047 clamps to the maximum.
  // Frames at the maximum size are cut short to keep the run brief.
  task automatic test_frame_sizes();
    run_frame(11'd0, 11'd0, 0, 1'b0, 1 << 20);
    run_frame(11'd2047, 11'd1, 0, 1'b0, 30);
    run_frame(11'd1, 11'd2047, 1, 1'b0, 30);
    run_frame(11'd0, 11'd3, 2, 1'b0, 1 << 20);
    run_frame(11'd2, 11'd1, 1, 1'b1, 1 << 20);
  endtask

  // Random small frames, some cut short and restarted.
  task automatic test_random_frames();
    int w, h, kept;
    while (items_sent < INPUT_ITEMS) begin
      w = $urandom_range(1, 9);
      h = $urandom_range(1, 7);
      kept = ($urandom_range(0, 7) == 0) ? $urandom_range(0, w * h - 1) : w * h;
      run_frame(w[CFG_W-1:0], h[CFG_W-1:0], $urandom_range(0, 2),
                1'($urandom_range(0, 1)), kept);
    end
  endtask

  initial begin
    error_count = 0;
    items_sent  = 0;
    cycle_count = 0;
    burst_left  = 0;
    ready_mode  = 0;
    rst_ni   = 1'b0;
    cfg_we   = 1'b0;
    cfg_idx  = REG_FRAME_WIDTH;
    cfg_data = '0;
    pix_in_bus.valid  = 1'b0;
    pix_in_bus.data   = '0;
    pix_out_bus.ready = 1'b0;
    width_reg  = FRAME_WIDTH_RST;
    height_reg = FRAME_HEIGHT_RST;
    for (int i = 0; i < DEF_MAX_WIDTH; i++) begin
      row_above[i] = '0;
      row_mid[i]   = '0;
    end
    for (int i = 0; i < 9; i++) window[i] = '0;
    restart_frame();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_directed_small();
    test_frame_sizes();
    test_random_frames();

    drain_results();
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
